/* design/i2ctbe_pkg.sv */
// Shared constants for the I2C target byte engine: phase codes, register
// indexes, timeout reset value, bit counter values and stream widths. No dependencies.
package i2ctbe_pkg;

  // Transfer phase codes, also reported on the result stream.
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_ADDR = 3'd1;
  localparam logic [2:0] PH_DATA = 3'd2;
  localparam logic [2:0] PH_WAIT = 3'd3;
  localparam logic [2:0] PH_STOP = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_OWN_ADDRESS  = 2'd0;
  localparam logic [1:0] REG_ENABLE       = 2'd1;
  localparam logic [1:0] REG_EDGE_TIMEOUT = 2'd2;

  localparam logic [7:0] TIMEOUT_RESET = 8'd10;

  // Bit counter values within one byte slot of data bits and acknowledge.
  localparam logic [3:0] BC_BYTE_DONE = 4'd8;
  localparam logic [3:0] BC_ACK_CLK   = 4'd9;
  localparam logic [3:0] BC_ACK_DONE  = 4'd10;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

endpackage

/* design/i2c_target_byte_engine.sv */
// I2C target byte engine top level: handshake, configuration registers and
// the per-sample bus state machine. Depends on i2ctbe_pkg.

// Each input transfer is one sample of SCL and SDA (plus the byte to send on a
// read) and yields exactly one result transfer carrying the SDA drive request,
// receive and transmit strobes, address match, busy flag and phase. One sample
// is taken every clock cycle unless stalled: the state update is a single short
// combinational pass from the accepted sample to the result register, and the
// input side is ready whenever the result register is empty or being emptied in
// the same cycle. The result of an accepted sample is valid in the next cycle.
// The block owns no SDA pad itself; sda_drive and sda_level are meant for an
// open-drain output stage. The enable register only gates new start detection.
module i2c_target_byte_engine
  import i2ctbe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // Configuration write port
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_addr,
  input  logic [7:0]             cfg_data,
  // Sample stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // scl_in[0], sda_in[1], tx_byte[9:2], zero fill[15:10]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // sda_drive[0], sda_level[1], rx_valid[2], rx_byte[10:3], tx_taken[11],
  // addr_match[12], busy_res[13], phase_out[16:14], zero fill[23:17]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // Configuration registers
  logic [6:0] own_address;
  logic       enable;
  logic [7:0] edge_timeout;

  // Bus engine state
  logic [2:0] phase;
  logic [3:0] bit_count;
  logic [7:0] shift_reg;
  logic       read_direction;
  logic [7:0] wait_count;
  logic       scl_prev;
  logic       sda_at_scl_high;
  logic       ack_pending;

  logic [2:0] phase_next;
  logic [3:0] bit_count_next;
  logic [7:0] shift_reg_next;
  logic       read_direction_next;
  logic [7:0] wait_count_next;
  logic       sda_at_scl_high_next;
  logic       ack_pending_next;

  // Result fields of the current sample
  logic       sda_drive;
  logic       sda_level;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       tx_taken;
  logic       addr_match;

  logic       scl_in;
  logic       sda_in;
  logic [7:0] tx_byte;
  logic       in_accept;
  logic       rise;
  logic       fall;
  logic       scl_edge;
  logic       changed_high;

  assign scl_in  = s_axis_tdata[0];
  assign sda_in  = s_axis_tdata[1];
  assign tx_byte = s_axis_tdata[9:2];

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign rise         = scl_in && !scl_prev;
  assign fall         = !scl_in && scl_prev;
  assign scl_edge     = rise || fall;
  assign changed_high = scl_in && scl_prev && (sda_in != sda_at_scl_high);

  // Configuration writes; indexes outside the register list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address  <= 7'd0;
      enable       <= 1'b0;
      edge_timeout <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_OWN_ADDRESS:  own_address  <= cfg_data[6:0];
        REG_ENABLE:       enable       <= cfg_data[0];
        REG_EDGE_TIMEOUT: edge_timeout <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Next state and result for one sample.
  always_comb begin
    phase_next           = phase;
    bit_count_next       = bit_count;
    shift_reg_next       = shift_reg;
    read_direction_next  = read_direction;
    wait_count_next      = wait_count;
    ack_pending_next     = ack_pending;
    sda_at_scl_high_next = rise ? sda_in : sda_at_scl_high;
    rx_valid             = 1'b0;
    rx_byte              = 8'd0;
    tx_taken             = 1'b0;
    addr_match           = 1'b0;

    case (phase)
      PH_IDLE: begin
        ack_pending_next = 1'b0;
        wait_count_next  = 8'd0;
        if (enable && scl_in && !sda_in) begin
          phase_next     = PH_ADDR;
          bit_count_next = 4'd0;
          shift_reg_next = 8'd0;
        end
      end

      PH_ADDR, PH_DATA: begin
        if (!scl_edge && wait_count >= edge_timeout) begin
          // Edge timeout: abandon the transfer.
          phase_next       = PH_STOP;
          ack_pending_next = 1'b0;
        end else begin
          wait_count_next = scl_edge ? 8'd0 : wait_count + 8'd1;
          if (phase == PH_DATA && read_direction) begin
            // Transmit byte, then sample the master's acknowledge.
            if (rise && bit_count < BC_BYTE_DONE) begin
              bit_count_next = bit_count + 4'd1;
            end else if (fall && bit_count >= 4'd1 && bit_count < BC_BYTE_DONE) begin
              shift_reg_next = {shift_reg[6:0], 1'b0};
            end else if (fall && bit_count == BC_BYTE_DONE) begin
              bit_count_next = BC_ACK_CLK;
            end else if (rise && bit_count == BC_ACK_CLK) begin
              if (!sda_in) begin
                bit_count_next = BC_ACK_DONE;
              end else begin
                phase_next      = PH_WAIT;
                wait_count_next = 8'd0;
                bit_count_next  = 4'd0;
              end
            end else if (fall && bit_count == BC_ACK_DONE) begin
              shift_reg_next = tx_byte;
              tx_taken       = 1'b1;
              bit_count_next = 4'd0;
            end
          end else if (bit_count < BC_BYTE_DONE) begin
            // Receive address or data bits.
            if (phase == PH_DATA && changed_high) begin
              phase_next       = PH_STOP;
              ack_pending_next = 1'b0;
            end else if (rise) begin
              shift_reg_next = {shift_reg[6:0], sda_in};
              bit_count_next = bit_count + 4'd1;
              if (phase == PH_ADDR && bit_count_next == BC_BYTE_DONE) begin
                if (shift_reg_next[7:1] == own_address) begin
                  addr_match          = 1'b1;
                  read_direction_next = shift_reg_next[0];
                end else begin
                  phase_next     = PH_IDLE;
                  bit_count_next = 4'd0;
                end
              end
            end
          end else if (bit_count == BC_BYTE_DONE) begin
            if (fall) begin
              ack_pending_next = 1'b1;
              bit_count_next   = BC_ACK_CLK;
            end
          end else if (bit_count == BC_ACK_CLK) begin
            if (rise) begin
              if (phase == PH_DATA) begin
                rx_valid = 1'b1;
                rx_byte  = shift_reg;
              end
              bit_count_next = BC_ACK_DONE;
            end
          end else if (fall) begin
            // End of the acknowledge clock.
            ack_pending_next = 1'b0;
            bit_count_next   = 4'd0;
            shift_reg_next   = 8'd0;
            if (phase == PH_ADDR) begin
              phase_next = PH_DATA;
              if (read_direction) begin
                shift_reg_next = tx_byte;
                tx_taken       = 1'b1;
              end
            end
          end
        end
      end

      PH_WAIT: begin
        ack_pending_next = 1'b0;
        if (!scl_in || rise) begin
          wait_count_next = 8'd0;
        end else if (changed_high || wait_count >= edge_timeout) begin
          phase_next = PH_STOP;
        end else begin
          wait_count_next = wait_count + 8'd1;
        end
      end

      default: begin
        // Stop lasts one sample; unused codes also fall back to idle.
        phase_next       = PH_IDLE;
        ack_pending_next = 1'b0;
        bit_count_next   = 4'd0;
        wait_count_next  = 8'd0;
      end
    endcase

    // SDA drive request after the update.
    if (ack_pending_next) begin
      sda_drive = 1'b1;
      sda_level = 1'b0;
    end else if (phase_next == PH_DATA && read_direction_next &&
                 bit_count_next <= BC_BYTE_DONE) begin
      sda_drive = 1'b1;
      sda_level = shift_reg_next[7];
    end else begin
      sda_drive = 1'b0;
      sda_level = 1'b0;
    end
  end

  // State update on each accepted sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      bit_count       <= 4'd0;
      shift_reg       <= 8'd0;
      read_direction  <= 1'b0;
      wait_count      <= 8'd0;
      scl_prev        <= 1'b1;
      sda_at_scl_high <= 1'b1;
      ack_pending     <= 1'b0;
    end else if (in_accept) begin
      phase           <= phase_next;
      bit_count       <= bit_count_next;
      shift_reg       <= shift_reg_next;
      read_direction  <= read_direction_next;
      wait_count      <= wait_count_next;
      scl_prev        <= scl_in;
      sda_at_scl_high <= sda_at_scl_high_next;
      ack_pending     <= ack_pending_next;
    end
  end

  // Result register: valid flag under reset, payload loaded on accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      m_axis_tdata <= {7'd0, phase_next, (phase_next != PH_IDLE), addr_match,
                       tx_taken, rx_byte, rx_valid, sda_level, sda_drive};
    end
  end

`ifndef SYNTHESIS
  // The bit counter never leaves the byte slot of data bits and acknowledge.
  assert property (@(posedge clk) disable iff (rst) bit_count <= BC_ACK_DONE)
    else $error("bit counter out of range");

  // Stop lasts exactly one accepted sample.
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && phase == PH_STOP) |=> (phase == PH_IDLE))
    else $error("stop phase did not return to idle");

  // An address match is reported only while still in the address phase.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[12]) |-> (m_axis_tdata[16:14] == PH_ADDR))
    else $error("address match outside address phase");

  // Receive and transmit strobes never coincide.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[2] && m_axis_tdata[11]))
    else $error("rx and tx strobes together");
`endif

endmodule
